// File: src/sms_pkg.sv
package sms_pkg;

  localparam int TICK_MS_DEFAULT = 20;

  // configuration register widths and reset values
  localparam int MPQ_W  = 12;
  localparam int DUTY_W = 14;
  localparam int DEG_W  = 9;

  localparam logic [MPQ_W-1:0]  MPQ_RESET        = 12'd344;
  localparam logic [DUTY_W-1:0] DUTY_CW_RESET    = 14'd500;
  localparam logic [DUTY_W-1:0] DUTY_CCW_RESET   = 14'd1000;
  localparam logic [DUTY_W-1:0] DUTY_HALT_RESET  = 14'd750;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MPQ_CW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MPQ_CCW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CCW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_HALT = 3'd4;

  // command codes
  localparam logic [7:0] CMD_CW_FULL  = 8'd0;
  localparam logic [7:0] CMD_CCW_FULL = 8'd1;
  localparam logic [7:0] CMD_CW_HALF  = 8'd2;
  localparam logic [7:0] CMD_CCW_HALF = 8'd3;
  localparam logic [7:0] CMD_CW_QTR   = 8'd4;
  localparam logic [7:0] CMD_CCW_QTR  = 8'd5;
  localparam logic [7:0] CMD_HOME     = 8'd6;
  localparam logic [7:0] CMD_DANCE    = 8'd7;
  localparam logic [7:0] CMD_RESET    = 8'hFF;

  localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;
  localparam logic [DEG_W-1:0] DEG_HALF = 9'd180;
  localparam logic [DEG_W-1:0] DEG_QTR  = 9'd90;

  // emotion codes
  localparam logic [2:0] EMO_NEUTRAL  = 3'd0;
  localparam logic [2:0] EMO_HAPPY    = 3'd1;
  localparam logic [2:0] EMO_SURPRISE = 3'd2;
  localparam logic [2:0] EMO_THINKING = 3'd3;
  localparam logic [2:0] EMO_ANGRY    = 3'd4;
  localparam logic [2:0] EMO_FEARFUL  = 3'd5;
  localparam logic [2:0] EMO_TOUCH    = 3'd6;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MOVE,
    PH_PAUSE
  } phase_t;

  typedef enum logic [2:0] {
    K_EMO,
    K_CW,
    K_CCW,
    K_PAUSE,
    K_END,
    K_NONE
  } step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic [DEG_W-1:0] val;   // degrees, pause ms or emotion code
  } step_t;

  localparam int DANCE_POS_W = 6;

  function automatic step_t emo_step(input logic [2:0] code);
    step_t s;
    s.kind = K_EMO;
    s.val  = {6'd0, code};
    return s;
  endfunction

  function automatic step_t dance_step(input logic [DANCE_POS_W-1:0] idx);
    step_t s;
    s.kind = K_NONE;
    s.val  = '0;
    case (idx)
      6'd0:  s = emo_step(EMO_HAPPY);
      6'd1:  s = '{K_CW,    9'd45};
      6'd2:  s = '{K_CCW,   9'd90};
      6'd3:  s = '{K_CW,    9'd90};
      6'd4:  s = '{K_CCW,   9'd45};
      6'd5:  s = '{K_PAUSE, 9'd300};
      6'd6:  s = emo_step(EMO_SURPRISE);
      6'd7:  s = '{K_CW,    9'd360};
      6'd8:  s = '{K_PAUSE, 9'd200};
      6'd9:  s = emo_step(EMO_THINKING);
      6'd10: s = '{K_CCW,   9'd60};
      6'd11: s = '{K_PAUSE, 9'd500};
      6'd12: s = '{K_CW,    9'd60};
      6'd13: s = '{K_PAUSE, 9'd300};
      6'd14: s = emo_step(EMO_ANGRY);
      6'd15: s = '{K_CW,    9'd30};
      6'd16: s = '{K_CCW,   9'd30};
      6'd17: s = '{K_CW,    9'd30};
      6'd18: s = '{K_CCW,   9'd30};
      6'd19: s = '{K_CW,    9'd30};
      6'd20: s = '{K_CCW,   9'd30};
      6'd21: s = '{K_CW,    9'd30};
      6'd22: s = '{K_CCW,   9'd30};
      6'd23: s = '{K_PAUSE, 9'd300};
      6'd24: s = emo_step(EMO_FEARFUL);
      6'd25: s = '{K_CCW,   9'd360};
      6'd26: s = '{K_PAUSE, 9'd200};
      6'd27: s = emo_step(EMO_TOUCH);
      6'd28: s = '{K_CW,    9'd180};
      6'd29: s = '{K_PAUSE, 9'd300};
      6'd30: s = emo_step(EMO_HAPPY);
      6'd31: s = '{K_CCW,   9'd90};
      6'd32: s = '{K_CW,    9'd90};
      6'd33: s = '{K_END,   9'd0};
      default: begin
        s.kind = K_NONE;
        s.val  = '0;
      end
    endcase
    return s;
  endfunction

endpackage

// File: src/servo_motion_sequencer_core.sv
// A result transfer is offered in the cycle after its input transfer.
// Throughput: one item per cycle; the input is held off only while the
// output register is full and not being drained.
// Run length of a move or pause is one 9x12 multiply plus offset and clamp, done in
// the accepting cycle. Reset (rst, synchronous): idle, heading 0, nothing
// pending, configuration registers back to their default values.
module servo_motion_sequencer_core #(
  parameter int TICK_MS = sms_pkg::TICK_MS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] command_code
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] pwm_enable, [14:1] duty_value, [23:15] heading, [24] busy_res,
  // [25] emotion_strobe, [28:26] emotion_code, [31:29] zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [sms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sms_pkg::DUTY_W-1:0]    cfg_data
);
  import sms_pkg::*;

  // Run timer counts in units of 1/90 ms; one tick is UNIT. floor(cnt/UNIT)
  // equals the ticks left, so no divider is needed.
  localparam int UNIT      = 90 * TICK_MS;
  localparam int MOVE_OFF  = 45 + 90 * (TICK_MS - 1);
  localparam int PAUSE_OFF = 90 * (TICK_MS - 1);
  localparam int CAP       = 1024 * UNIT - 1;
  localparam int CNT_W     = $clog2(CAP + 1);
  localparam int PROD_W    = DEG_W + MPQ_W;
  localparam int SUM_W     = $clog2((2 ** PROD_W) + MOVE_OFF + 1);
  localparam int WIDE_W    = (SUM_W > CNT_W) ? SUM_W : CNT_W;

  // configuration
  logic [MPQ_W-1:0]  mpq_cw, mpq_ccw;
  logic [DUTY_W-1:0] duty_cw, duty_ccw, duty_halt;

  // state
  phase_t                 phase, phase_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [DEG_W-1:0]       tracked, tracked_next;
  logic [DEG_W-1:0]       after, after_next;
  logic                   armed, armed_next;
  logic                   dance_active, dance_active_next;
  logic [DANCE_POS_W-1:0] dance_pos, dance_pos_next;
  logic                   move_cw, move_cw_next;
  logic                   pend_valid, pend_valid_next;
  logic [7:0]             pend_cmd, pend_cmd_next;

  // step logic
  logic                   in_xfer, op_tick;
  logic                   take, dance;
  logic [DANCE_POS_W-1:0] dance_base;
  step_t                  step0, step1, act;
  logic                   start_move, start_pause, start_cw;
  logic [DEG_W-1:0]       start_deg;
  logic                   arm;
  logic [DEG_W-1:0]       arm_add;
  logic [DEG_W:0]         angle_sum;
  logic [MPQ_W-1:0]       mul_b;
  logic [PROD_W-1:0]      prod;
  logic [WIDE_W-1:0]      run_sum, run_clamped;
  logic                   emo_strobe;
  logic [2:0]             emo_code;
  logic [DUTY_W-1:0]      duty;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign op_tick       = s_axis_tuser[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mpq_cw    <= MPQ_RESET;
      mpq_ccw   <= MPQ_RESET;
      duty_cw   <= DUTY_CW_RESET;
      duty_ccw  <= DUTY_CCW_RESET;
      duty_halt <= DUTY_HALT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MPQ_CW:    mpq_cw    <= cfg_data[MPQ_W-1:0];
        REG_MPQ_CCW:   mpq_ccw   <= cfg_data[MPQ_W-1:0];
        REG_DUTY_CW:   duty_cw   <= cfg_data;
        REG_DUTY_CCW:  duty_ccw  <= cfg_data;
        REG_DUTY_HALT: duty_halt <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    cnt_next          = cnt;
    tracked_next      = tracked;
    after_next        = after;
    armed_next        = armed;
    dance_active_next = dance_active;
    dance_pos_next    = dance_pos;
    move_cw_next      = move_cw;
    pend_valid_next   = pend_valid;
    pend_cmd_next     = pend_cmd;
    emo_strobe        = 1'b0;
    emo_code          = EMO_NEUTRAL;
    take              = 1'b0;
    dance             = 1'b0;
    dance_base        = dance_pos;
    start_move        = 1'b0;
    start_pause       = 1'b0;
    start_cw          = 1'b0;
    start_deg         = '0;
    arm               = 1'b0;
    arm_add           = '0;
    step0             = '0;
    step1             = '0;
    act               = step0;

    if (!op_tick) begin
      pend_cmd_next   = s_axis_tdata;
      pend_valid_next = 1'b1;
    end else begin
      case (phase)
        PH_MOVE: begin
          if (pend_valid) begin
            take = 1'b1;
          end else if (cnt < CNT_W'(2 * UNIT)) begin
            phase_next = PH_IDLE;
            cnt_next   = '0;
            if (armed) begin
              tracked_next = after;
              armed_next   = 1'b0;
            end
            dance = dance_active;
          end else begin
            cnt_next = cnt - CNT_W'(UNIT);
          end
        end
        PH_PAUSE: begin
          if (cnt < CNT_W'(2 * UNIT)) begin
            phase_next = PH_IDLE;
            cnt_next   = '0;
            if (pend_valid) take = 1'b1;
            else dance = dance_active;
          end else begin
            cnt_next = cnt - CNT_W'(UNIT);
          end
        end
        default: begin
          if (pend_valid) take = 1'b1;
        end
      endcase
    end

    if (take) begin
      phase_next        = PH_IDLE;
      cnt_next          = '0;
      armed_next        = 1'b0;
      dance_active_next = 1'b0;
      pend_valid_next   = 1'b0;
      case (pend_cmd)
        CMD_CW_FULL: begin
          start_move = 1'b1; start_cw = 1'b1; start_deg = DEG_FULL;
        end
        CMD_CCW_FULL: begin
          start_move = 1'b1; start_deg = DEG_FULL;
        end
        CMD_CW_HALF: begin
          start_move = 1'b1; start_cw = 1'b1; start_deg = DEG_HALF;
          arm = 1'b1; arm_add = DEG_HALF;
        end
        CMD_CCW_HALF: begin
          start_move = 1'b1; start_deg = DEG_HALF;
          arm = 1'b1; arm_add = DEG_HALF;
        end
        CMD_CW_QTR: begin
          start_move = 1'b1; start_cw = 1'b1; start_deg = DEG_QTR;
          arm = 1'b1; arm_add = DEG_QTR;
        end
        CMD_CCW_QTR: begin
          start_move = 1'b1; start_deg = DEG_QTR;
          arm = 1'b1; arm_add = DEG_FULL - DEG_QTR;
        end
        CMD_HOME: begin
          // heading lands on zero once the move completes; below 180 (and at 180) go ccw
          if (tracked != '0) begin
            start_move = 1'b1;
            arm        = 1'b1;
            arm_add    = DEG_FULL - tracked;
            if (tracked <= DEG_HALF) begin
              start_deg = tracked;
            end else begin
              start_cw  = 1'b1;
              start_deg = DEG_FULL - tracked;
            end
          end
        end
        CMD_DANCE: begin
          dance_active_next = 1'b1;
          dance             = 1'b1;
          dance_base        = '0;
        end
        default: ;
      endcase
    end

    if (dance) begin
      step0 = dance_step(dance_base);
      step1 = dance_step(dance_base + DANCE_POS_W'(1));
      // an emotion entry is always followed by a timed entry
      if (step0.kind == K_EMO) begin
        emo_strobe = 1'b1;
        emo_code   = step0.val[2:0];
        act        = step1;
        dance_pos_next = (step1.kind == K_NONE) ? dance_base + DANCE_POS_W'(1)
                                                : dance_base + DANCE_POS_W'(2);
      end else begin
        act = step0;
        dance_pos_next = (step0.kind == K_NONE) ? dance_base
                                                : dance_base + DANCE_POS_W'(1);
      end
      case (act.kind)
        K_CW: begin
          start_move = 1'b1; start_cw = 1'b1; start_deg = act.val;
        end
        K_CCW: begin
          start_move = 1'b1; start_deg = act.val;
        end
        K_PAUSE: begin
          start_pause = 1'b1; start_deg = act.val;
        end
        K_END: begin
          emo_strobe        = 1'b1;
          emo_code          = EMO_NEUTRAL;
          tracked_next      = '0;
          dance_active_next = 1'b0;
          phase_next        = PH_IDLE;
        end
        default: begin
          dance_active_next = 1'b0;
          phase_next        = PH_IDLE;
        end
      endcase
    end

    angle_sum = {1'b0, tracked} + {1'b0, arm_add};
    if (arm) begin
      after_next = (angle_sum >= {1'b0, DEG_FULL}) ? DEG_W'(angle_sum - {1'b0, DEG_FULL})
                                                   : angle_sum[DEG_W-1:0];
      armed_next = 1'b1;
    end

    // move: deg*ms_per_quarter + 45 + 90*(TICK_MS-1); pause: ms*90 + 90*(TICK_MS-1)
    if (start_pause)   mul_b = MPQ_W'(90);
    else if (start_cw) mul_b = mpq_cw;
    else               mul_b = mpq_ccw;
    prod    = PROD_W'(start_deg) * PROD_W'(mul_b);
    run_sum = WIDE_W'(prod) + (start_pause ? WIDE_W'(PAUSE_OFF) : WIDE_W'(MOVE_OFF));
    if (run_sum < WIDE_W'(UNIT))     run_clamped = WIDE_W'(UNIT);
    else if (run_sum > WIDE_W'(CAP)) run_clamped = WIDE_W'(CAP);
    else                             run_clamped = run_sum;

    if (start_move) begin
      phase_next   = PH_MOVE;
      move_cw_next = start_cw;
      cnt_next     = run_clamped[CNT_W-1:0];
    end else if (start_pause) begin
      phase_next = PH_PAUSE;
      cnt_next   = run_clamped[CNT_W-1:0];
    end
  end

  always_comb begin
    if (phase_next != PH_MOVE) duty = duty_halt;
    else if (move_cw_next)     duty = duty_cw;
    else                       duty = duty_ccw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cnt           <= '0;
      tracked       <= '0;
      after         <= '0;
      armed         <= 1'b0;
      dance_active  <= 1'b0;
      dance_pos     <= '0;
      move_cw       <= 1'b0;
      pend_valid    <= 1'b0;
      pend_cmd      <= CMD_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase        <= phase_next;
        cnt          <= cnt_next;
        tracked      <= tracked_next;
        after        <= after_next;
        armed        <= armed_next;
        dance_active <= dance_active_next;
        dance_pos    <= dance_pos_next;
        move_cw      <= move_cw_next;
        pend_valid   <= pend_valid_next;
        pend_cmd     <= pend_cmd_next;
      end
      if (in_xfer) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_axis_tdata <= {3'b000, emo_code, emo_strobe, (phase_next != PH_IDLE),
                       tracked_next, duty, (phase_next == PH_MOVE)};
    end
  end

endmodule
